/* rtl/fbfl_pkg.sv */
// fbfl_pkg: shared types, codes and widths of the fixed-block free-list allocator
`default_nettype none

package fbfl_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 256;
    localparam int INDEX_REACH        = 256;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int LINK_W   = 9;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT  = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_FORMAT,
        FSM_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic in_ready;
        logic fmt_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_is_format;
        logic fmt_none;
        logic fmt_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/fbfl_ctrl.sv */
// fbfl_ctrl: sequencing state machine of the free-list allocator
`default_nettype none

module fbfl_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  fbfl_pkg::dp_status_t    status,
    output fbfl_pkg::ctrl_cmd_t     ctrl
);

    fbfl_pkg::fsm_state_t state_reg;
    fbfl_pkg::fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbfl_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fbfl_pkg::FSM_IDLE: begin
                if (status.in_valid) begin
                    if (status.in_is_format && !status.fmt_none) begin
                        state_next = fbfl_pkg::FSM_FORMAT;
                    end else begin
                        state_next = fbfl_pkg::FSM_FINISH;
                    end
                end
            end
            fbfl_pkg::FSM_FORMAT: begin
                if (status.fmt_last) begin
                    state_next = fbfl_pkg::FSM_FINISH;
                end
            end
            fbfl_pkg::FSM_FINISH: begin
                if (status.out_free) begin
                    state_next = fbfl_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = fbfl_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            fbfl_pkg::FSM_IDLE:   ctrl.in_ready = 1'b1;
            fbfl_pkg::FSM_FORMAT: ctrl.fmt_step = 1'b1;
            fbfl_pkg::FSM_FINISH: ctrl.commit   = status.out_free;
            default:              ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/fbfl_dp.sv */
// fbfl_dp: link store, head and count registers, and result register
`default_nettype none

module fbfl_dp #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  fbfl_pkg::ctrl_cmd_t             ctrl,
    output fbfl_pkg::dp_status_t            status,
    input  wire                             s_tvalid,
    input  wire [fbfl_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [fbfl_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire                             cfg_valid,
    input  wire [fbfl_pkg::COUNT_W-1:0]     cfg_data
);

    localparam int DEPTH  = (MAX_BLOCKS < fbfl_pkg::INDEX_REACH) ?
                            MAX_BLOCKS : fbfl_pkg::INDEX_REACH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [fbfl_pkg::COUNT_W-1:0] DEPTH_CAP = fbfl_pkg::COUNT_W'(DEPTH);

    logic [fbfl_pkg::LINK_W-1:0]    link_mem [DEPTH];
    logic [fbfl_pkg::LINK_W-1:0]    rd_link_reg;

    logic [fbfl_pkg::COUNT_W-1:0]   num_blocks_reg;
    logic [fbfl_pkg::LINK_W-1:0]    head_reg;
    logic [fbfl_pkg::LINK_W-1:0]    head_next;
    logic [fbfl_pkg::COUNT_W-1:0]   free_reg;
    logic [fbfl_pkg::COUNT_W-1:0]   free_next;
    logic [fbfl_pkg::COUNT_W-1:0]   pool_reg;
    logic [fbfl_pkg::COUNT_W-1:0]   pool_next;
    logic [fbfl_pkg::COUNT_W-1:0]   fmt_cnt_reg;
    logic [fbfl_pkg::COUNT_W-1:0]   fmt_cnt_inc;

    fbfl_pkg::cmd_t                 cmd_reg;
    logic [fbfl_pkg::IDX_W-1:0]     bidx_reg;

    logic [fbfl_pkg::COUNT_W-1:0]   n_sat;
    logic [fbfl_pkg::COUNT_W-1:0]   bidx_ext;
    logic                           accept;
    logic                           out_valid_reg;
    logic [fbfl_pkg::M_DATA_W-1:0]  out_data_reg;

    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [fbfl_pkg::LINK_W-1:0]    wr_data;
    logic [fbfl_pkg::IDX_W-1:0]     granted;
    fbfl_pkg::status_t              res_status;

    assign accept      = ctrl.in_ready && s_tvalid;
    assign n_sat       = (num_blocks_reg > DEPTH_CAP) ? DEPTH_CAP : num_blocks_reg;
    assign fmt_cnt_inc = fmt_cnt_reg + fbfl_pkg::COUNT_W'(1);
    assign bidx_ext    = {1'b0, bidx_reg};

    assign status.in_valid     = s_tvalid;
    assign status.in_is_format = (fbfl_pkg::cmd_t'(s_tdata[fbfl_pkg::CMD_W-1:0])
                                  == fbfl_pkg::CMD_FORMAT);
    assign status.fmt_none     = (n_sat == '0);
    assign status.fmt_last     = (fmt_cnt_inc == n_sat);
    assign status.out_free     = !out_valid_reg || m_tready;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blocks_reg <= fbfl_pkg::COUNT_W'(fbfl_pkg::INDEX_REACH);
        end else if (cfg_valid) begin
            num_blocks_reg <= cfg_data;
        end
    end

    // item capture and format sweep counter
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= fbfl_pkg::cmd_t'(s_tdata[fbfl_pkg::CMD_W-1:0]);
            bidx_reg    <= s_tdata[fbfl_pkg::CMD_W +: fbfl_pkg::IDX_W];
            fmt_cnt_reg <= '0;
        end else if (ctrl.fmt_step) begin
            fmt_cnt_reg <= fmt_cnt_inc;
        end
    end

    // commit of one item, and link writes of the format sweep
    always_comb begin
        head_next  = head_reg;
        free_next  = free_reg;
        pool_next  = pool_reg;
        granted    = '0;
        res_status = fbfl_pkg::ST_OK;
        wr_en      = 1'b0;
        wr_addr    = fmt_cnt_reg[ADDR_W-1:0];
        wr_data    = fmt_cnt_inc;
        if (ctrl.fmt_step) begin
            wr_en = 1'b1;
        end
        unique case (cmd_reg)
            fbfl_pkg::CMD_FORMAT: begin
                pool_next = n_sat;
                free_next = n_sat;
                head_next = '0;
            end
            fbfl_pkg::CMD_ACQUIRE: begin
                if (free_reg == '0) begin
                    res_status = fbfl_pkg::ST_EMPTY;
                end else begin
                    granted   = head_reg[fbfl_pkg::IDX_W-1:0];
                    head_next = rd_link_reg;
                    free_next = free_reg - fbfl_pkg::COUNT_W'(1);
                end
            end
            fbfl_pkg::CMD_RELEASE: begin
                priority if (bidx_ext >= pool_reg) begin
                    res_status = fbfl_pkg::ST_RANGE;
                end else if (free_reg >= pool_reg) begin
                    res_status = fbfl_pkg::ST_FULL;
                end else begin
                    head_next = bidx_ext;
                    free_next = free_reg + fbfl_pkg::COUNT_W'(1);
                    if (ctrl.commit) begin
                        wr_en   = 1'b1;
                        wr_addr = bidx_reg[ADDR_W-1:0];
                        wr_data = head_reg;
                    end
                end
            end
            default: begin
                res_status = fbfl_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_link_reg <= link_mem[head_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            free_reg <= '0;
            pool_reg <= '0;
        end else if (ctrl.commit) begin
            head_reg <= head_next;
            free_reg <= free_next;
            pool_reg <= pool_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            out_data_reg <= {5'd0, free_next, res_status, granted};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/fixed_block_free_list_allocator.sv */
// fixed_block_free_list_allocator: top level of the fixed-block free-list allocator
//
//  channel   direction  fields (lowest bit up)
//  s_        in         tdata: cmd[1:0], block_index[9:2], zero fill
//  m_        out        tdata: granted_index[7:0], status[9:8], free_count[18:10], zero fill
//  cfg_      in         cfg_data: num_blocks[8:0]
//
// acquire, release and unused commands go through accept, then commit
// after the registered link-store read
// format writes n links, n the saturated block count, one link written per cycle
// a finished result waiting in the output register holds only the commit of the next item
// aresetn is synchronous; it empties the pool, the link store keeps no reset
`default_nettype none

module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [fbfl_pkg::S_DATA_W-1:0]    s_tdata,   // cmd, block_index
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [fbfl_pkg::M_DATA_W-1:0]   m_tdata,   // granted_index, status, free_count
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [fbfl_pkg::COUNT_W-1:0]     cfg_data
);

    fbfl_pkg::ctrl_cmd_t  ctrl;
    fbfl_pkg::dp_status_t status;

    fbfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    fbfl_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

    assign s_tready  = ctrl.in_ready;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one still in work");

    a_commit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |-> (!m_tvalid || m_tready))
        else $error("commit would overwrite an untaken result");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> m_tvalid)
        else $error("committed item gave no result");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[9:8] == fbfl_pkg::ST_EMPTY))
            |-> (m_tdata[7:0] == '0 && m_tdata[18:10] == '0))
        else $error("empty status with a grant or free blocks");
`endif

endmodule

`default_nettype wire
